// File: rtl/core/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

  localparam int HUE_W  = 13;
  localparam int SV_W   = 9;
  localparam int BRI_W  = 5;
  localparam int CH_W   = 8;
  localparam int F_W    = 10;
  localparam int PROD_W = 17;
  localparam int NUM_W  = 27;
  localparam int SCALE_W = NUM_W + 5;
  localparam int CHAN_SHIFT = 22;

  localparam logic [HUE_W-1:0] HUE_LIMIT    = 13'd5760;
  localparam logic [F_W-1:0]   SECTOR_UNITS = 10'd960;
  localparam logic [SV_W-1:0]  UNIT_SV      = 9'd256;
  localparam logic [4:0]       CHAN_MULT    = 5'd17;
  localparam logic [CH_W-1:0]  CH_MAX       = 8'hFF;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
    logic [HUE_W-1:0] base;
    case (sec)
      SEC_RY:  base = 13'd0;
      SEC_YG:  base = 13'd960;
      SEC_GC:  base = 13'd1920;
      SEC_CB:  base = 13'd2880;
      SEC_BM:  base = 13'd3840;
      SEC_MR:  base = 13'd4800;
      default: base = 13'd0;
    endcase
    return base;
  endfunction

  // numerator is over 2^16 * 960; times 255 over that is times 17 over 2^22
  function automatic logic [CH_W-1:0] to_channel(input logic [NUM_W-1:0] num);
    logic [SCALE_W-1:0]            scaled;
    logic [SCALE_W-CHAN_SHIFT-1:0] chan;
    scaled = SCALE_W'(num) * SCALE_W'(CHAN_MULT);
    chan   = scaled[SCALE_W-1:CHAN_SHIFT];
    return (|chan[SCALE_W-CHAN_SHIFT-1:CH_W]) ? CH_MAX : chan[CH_W-1:0];
  endfunction

endpackage

// File: rtl/core/hsv_to_rgb_pixel_unit.sv
`timescale 1ns / 1ps

// HSV to RGB pixel converter. Hue is in 1/16 degree (0..5759; 5760 and up
// drops the colour part and leaves only the grey level v*(1-s)), saturation
// and value are n/256 and clamp at 256. Each channel is
// floor((channel'+m)*255), and brightness is carried through to
// brightness_out. Five register stages (sector split, s*v, the hue
// product, channel select, scale by 255) lie between an accepted input
// word and out_valid; one word is accepted in every clock while in_stall
// is low, and out_stall holds the whole pipeline, so in_stall follows it
// in the same cycle while the output register is full.
module hsv_to_rgb_pixel_unit
  import hsvrgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [HUE_W-1:0] hue,
  input  logic [SV_W-1:0]  saturation,
  input  logic [SV_W-1:0]  value,
  input  logic [BRI_W-1:0] brightness,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CH_W-1:0]  red,
  output logic [CH_W-1:0]  green,
  output logic [CH_W-1:0]  blue,
  output logic [BRI_W-1:0] brightness_out
);

  logic en;

  logic             s1_valid;
  logic [SV_W-1:0]  s1_sat;
  logic [SV_W-1:0]  s1_val;
  sector_t          s1_sector;
  logic [F_W-1:0]   s1_f;
  logic             s1_in_range;
  logic [BRI_W-1:0] s1_bri;

  logic              s2_valid;
  logic [PROD_W-1:0] s2_sv;
  logic [F_W-1:0]    s2_g;
  logic [SV_W-1:0]   s2_val;
  sector_t           s2_sector;
  logic              s2_in_range;
  logic [BRI_W-1:0]  s2_bri;

  logic             s3_valid;
  logic [NUM_W-1:0] s3_xn;
  logic [NUM_W-1:0] s3_cn;
  logic [NUM_W-1:0] s3_vn;
  sector_t          s3_sector;
  logic             s3_in_range;
  logic [BRI_W-1:0] s3_bri;

  logic             s4_valid;
  logic [NUM_W-1:0] s4_red_num;
  logic [NUM_W-1:0] s4_green_num;
  logic [NUM_W-1:0] s4_blue_num;
  logic [BRI_W-1:0] s4_bri;

  logic [SV_W-1:0]  sat_clamp;
  logic [SV_W-1:0]  val_clamp;
  sector_t          sector_next;
  logic [HUE_W-1:0] f_full;
  logic [NUM_W-1:0] base_num;
  logic [NUM_W:0]   xs_sum;
  logic [NUM_W-1:0] xs_num;
  logic [NUM_W-1:0] red_next;
  logic [NUM_W-1:0] green_next;
  logic [NUM_W-1:0] blue_next;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    sat_clamp = (saturation > UNIT_SV) ? UNIT_SV : saturation;
    val_clamp = (value > UNIT_SV) ? UNIT_SV : value;
    if (hue < sector_base(SEC_YG)) begin
      sector_next = SEC_RY;
    end else if (hue < sector_base(SEC_GC)) begin
      sector_next = SEC_YG;
    end else if (hue < sector_base(SEC_CB)) begin
      sector_next = SEC_GC;
    end else if (hue < sector_base(SEC_BM)) begin
      sector_next = SEC_CB;
    end else if (hue < sector_base(SEC_MR)) begin
      sector_next = SEC_BM;
    end else begin
      sector_next = SEC_MR;
    end
    f_full = hue - sector_base(sector_next);
  end

  always_comb begin
    base_num = s3_vn - s3_cn;
    xs_sum   = {1'b0, base_num} + {1'b0, s3_xn};
    xs_num   = xs_sum[NUM_W-1:0];
    case (s3_sector)
      SEC_RY: begin
        red_next = s3_vn;    green_next = xs_num;   blue_next = base_num;
      end
      SEC_YG: begin
        red_next = xs_num;   green_next = s3_vn;    blue_next = base_num;
      end
      SEC_GC: begin
        red_next = base_num; green_next = s3_vn;    blue_next = xs_num;
      end
      SEC_CB: begin
        red_next = base_num; green_next = xs_num;   blue_next = s3_vn;
      end
      SEC_BM: begin
        red_next = xs_num;   green_next = base_num; blue_next = s3_vn;
      end
      default: begin
        red_next = s3_vn;    green_next = base_num; blue_next = xs_num;
      end
    endcase
    if (!s3_in_range) begin
      red_next   = base_num;
      green_next = base_num;
      blue_next  = base_num;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sat      <= sat_clamp;
      s1_val      <= val_clamp;
      s1_sector   <= sector_next;
      s1_f        <= f_full[F_W-1:0];
      s1_in_range <= (hue < HUE_LIMIT);
      s1_bri      <= brightness;

      s2_sv       <= PROD_W'(s1_sat) * PROD_W'(s1_val);
      s2_g        <= s1_sector[0] ? (SECTOR_UNITS - s1_f) : s1_f;
      s2_val      <= s1_val;
      s2_sector   <= s1_sector;
      s2_in_range <= s1_in_range;
      s2_bri      <= s1_bri;

      s3_xn       <= NUM_W'(s2_sv) * NUM_W'(s2_g);
      s3_cn       <= NUM_W'(s2_sv) * NUM_W'(SECTOR_UNITS);
      s3_vn       <= NUM_W'({s2_val, 8'b0}) * NUM_W'(SECTOR_UNITS);
      s3_sector   <= s2_sector;
      s3_in_range <= s2_in_range;
      s3_bri      <= s2_bri;

      s4_red_num   <= red_next;
      s4_green_num <= green_next;
      s4_blue_num  <= blue_next;
      s4_bri       <= s3_bri;

      red            <= to_channel(s4_red_num);
      green          <= to_channel(s4_green_num);
      blue           <= to_channel(s4_blue_num);
      brightness_out <= s4_bri;
    end
  end

  a_stall_follows_output : assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the full, stalled output register");

  a_latency : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall
      |=> out_valid)
    else $error("accepted word did not reach the output after five cycles");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(s4_red_num) && $stable(s4_green_num) && $stable(s4_blue_num)
             && $stable(s4_valid) && $stable(s1_valid)))
    else $error("pipeline advanced while the output was stalled");

endmodule
